>>> rtl/csmc_pkg.sv
// ============================================================================
// csmc_pkg
// Shared types and constants for the complex scaled matrix copy block.
// ============================================================================
package csmc_pkg;

    localparam int CFG_DIM_W  = 13;   // row/col counts and strides
    localparam int SCALE_W    = 16;   // alpha parts, Q3.12
    localparam int SCALE_FRAC = 12;
    localparam int IDX_W      = 24;   // destination index in B
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_MAJOR  = 3'd0,
        REG_TRANS_MODE = 3'd1,
        REG_ROW_COUNT  = 3'd2,
        REG_COL_COUNT  = 3'd3,
        REG_SRC_STRIDE = 3'd4,
        REG_DST_STRIDE = 3'd5,
        REG_SCALE_RE   = 3'd6,
        REG_SCALE_IM   = 3'd7
    } cfg_reg_t;

    // error codes reported with each result word
    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_ROWS_ZERO  = 3'd1,
        ERR_COLS_ZERO  = 3'd2,
        ERR_SRC_STRIDE = 3'd3,
        ERR_DST_STRIDE = 3'd4
    } err_code_t;

    // trans_mode bits: bit 0 conjugate, bit 1 transpose
    localparam int TM_CONJ_BIT  = 0;
    localparam int TM_TRANS_BIT = 1;

    localparam logic signed [SCALE_W-1:0] SCALE_RE_RESET = 16'sd4096;

    typedef struct packed {
        logic                        row_major;
        logic [1:0]                  trans_mode;
        logic [CFG_DIM_W-1:0]        row_count;
        logic [CFG_DIM_W-1:0]        col_count;
        logic [CFG_DIM_W-1:0]        src_stride;
        logic [CFG_DIM_W-1:0]        dst_stride;
        logic signed [SCALE_W-1:0]   scale_re;
        logic signed [SCALE_W-1:0]   scale_im;
    } cfg_t;

endpackage

>>> rtl/csmc_cfg_regs.sv
// ============================================================================
// csmc_cfg_regs
// Configuration register file and argument check.
// ============================================================================
module csmc_cfg_regs (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csmc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output csmc_pkg::cfg_t                       cfg,
    output csmc_pkg::err_code_t                  err
);

    csmc_pkg::cfg_t cfg_reg;
    csmc_pkg::cfg_t cfg_next;

    logic                              trans;
    logic [csmc_pkg::CFG_DIM_W-1:0]    src_need;
    logic [csmc_pkg::CFG_DIM_W-1:0]    dst_need;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (csmc_pkg::cfg_reg_t'(cfg_index))
                csmc_pkg::REG_ROW_MAJOR:  cfg_next.row_major  = cfg_data[0];
                csmc_pkg::REG_TRANS_MODE: cfg_next.trans_mode = cfg_data[1:0];
                csmc_pkg::REG_ROW_COUNT:
                    cfg_next.row_count  = cfg_data[csmc_pkg::CFG_DIM_W-1:0];
                csmc_pkg::REG_COL_COUNT:
                    cfg_next.col_count  = cfg_data[csmc_pkg::CFG_DIM_W-1:0];
                csmc_pkg::REG_SRC_STRIDE:
                    cfg_next.src_stride = cfg_data[csmc_pkg::CFG_DIM_W-1:0];
                csmc_pkg::REG_DST_STRIDE:
                    cfg_next.dst_stride = cfg_data[csmc_pkg::CFG_DIM_W-1:0];
                csmc_pkg::REG_SCALE_RE:   cfg_next.scale_re   = $signed(cfg_data);
                csmc_pkg::REG_SCALE_IM:   cfg_next.scale_im   = $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_major  <= 1'b0;
            cfg_reg.trans_mode <= '0;
            cfg_reg.row_count  <= '0;
            cfg_reg.col_count  <= '0;
            cfg_reg.src_stride <= '0;
            cfg_reg.dst_stride <= '0;
            cfg_reg.scale_re   <= csmc_pkg::SCALE_RE_RESET;
            cfg_reg.scale_im   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // stride needs: A follows storage order, B swaps in transposed modes
    assign trans    = cfg_reg.trans_mode[csmc_pkg::TM_TRANS_BIT];
    assign src_need = cfg_reg.row_major ? cfg_reg.col_count : cfg_reg.row_count;
    assign dst_need = (cfg_reg.row_major ^ trans) ? cfg_reg.col_count
                                                  : cfg_reg.row_count;

    // dst stride check overrides all others
    always_comb begin
        priority if (cfg_reg.dst_stride < dst_need) err = csmc_pkg::ERR_DST_STRIDE;
        else if (cfg_reg.row_count == '0)           err = csmc_pkg::ERR_ROWS_ZERO;
        else if (cfg_reg.col_count == '0)           err = csmc_pkg::ERR_COLS_ZERO;
        else if (cfg_reg.src_stride < src_need)     err = csmc_pkg::ERR_SRC_STRIDE;
        else                                        err = csmc_pkg::ERR_NONE;
    end

endmodule

>>> rtl/csmc_pos_ctr.sv
// ============================================================================
// csmc_pos_ctr
// Outer/inner loop position counters over the elements of A.
// ============================================================================
module csmc_pos_ctr #(
    parameter int MAX_DIM = 4096
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  csmc_pkg::cfg_t                       cfg,
    input  logic                                 advance,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] outer_cur,
    output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM) : 1)-1:0] inner_cur,
    output logic                                 last
);

    localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int NW    = (POS_W + 1 > csmc_pkg::CFG_DIM_W) ? POS_W + 1
                                                             : csmc_pkg::CFG_DIM_W;
    localparam logic [NW-1:0] MAX_N = NW'(MAX_DIM);

    logic [POS_W-1:0] outer_reg, outer_next;
    logic [POS_W-1:0] inner_reg, inner_next;

    logic [NW-1:0] row_n, col_n, n_outer, n_inner;
    logic [NW-1:0] outer_inc, inner_inc;
    logic          inner_wrap, outer_wrap;

    assign row_n = (NW'(cfg.row_count) > MAX_N) ? MAX_N : NW'(cfg.row_count);
    assign col_n = (NW'(cfg.col_count) > MAX_N) ? MAX_N : NW'(cfg.col_count);
    assign n_outer = cfg.row_major ? row_n : col_n;
    assign n_inner = cfg.row_major ? col_n : row_n;

    // a position left beyond a shrunken count restarts at zero
    assign outer_cur = (NW'(outer_reg) >= n_outer) ? '0 : outer_reg;
    assign inner_cur = (NW'(inner_reg) >= n_inner) ? '0 : inner_reg;

    assign outer_inc  = NW'(outer_cur) + NW'(1);
    assign inner_inc  = NW'(inner_cur) + NW'(1);
    assign inner_wrap = !(inner_inc < n_inner);
    assign outer_wrap = !(outer_inc < n_outer);
    assign last       = (outer_inc == n_outer) && (inner_inc == n_inner);

    always_comb begin
        outer_next = outer_reg;
        inner_next = inner_reg;
        if (advance) begin
            if (!inner_wrap) begin
                inner_next = inner_inc[POS_W-1:0];
                outer_next = outer_cur;
            end else begin
                inner_next = '0;
                outer_next = outer_wrap ? '0 : outer_inc[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            outer_reg <= '0;
            inner_reg <= '0;
        end else begin
            outer_reg <= outer_next;
            inner_reg <= inner_next;
        end
    end

endmodule

>>> rtl/csmc_cmul.sv
// ============================================================================
// csmc_cmul
// Complex multiply by Q3.12 alpha with optional conjugate, round and saturate.
// ============================================================================
module csmc_cmul #(
    parameter int DATA_WIDTH = 16
) (
    input  logic signed [DATA_WIDTH-1:0]             a_re,
    input  logic signed [DATA_WIDTH-1:0]             a_im,
    input  logic                                     conj,
    input  logic signed [csmc_pkg::SCALE_W-1:0]      scale_re,
    input  logic signed [csmc_pkg::SCALE_W-1:0]      scale_im,
    output logic signed [DATA_WIDTH-1:0]             p_re,
    output logic signed [DATA_WIDTH-1:0]             p_im
);

    localparam int EW = DATA_WIDTH + 1;           // room to negate the minimum
    localparam int PW = EW + csmc_pkg::SCALE_W;
    localparam int SW = PW + 1;
    localparam int RW = SW - csmc_pkg::SCALE_FRAC;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (csmc_pkg::SCALE_FRAC - 1);

    logic signed [EW-1:0] er, ei;
    logic signed [PW-1:0] rr, ii, ri, ir;
    logic signed [SW-1:0] sum_re, sum_im;
    logic signed [RW-1:0] rnd_re, rnd_im;

    function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
        logic signed [DATA_WIDTH-1:0] r;
        // in range when all bits above the result's sign match it
        if (v[RW-1:DATA_WIDTH-1] == '0 || v[RW-1:DATA_WIDTH-1] == '1)
            r = v[DATA_WIDTH-1:0];
        else if (v[RW-1])
            r = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        return r;
    endfunction

    assign er = EW'(a_re);
    assign ei = conj ? -EW'(a_im) : EW'(a_im);

    assign rr = PW'(scale_re) * PW'(er);
    assign ii = PW'(scale_im) * PW'(ei);
    assign ri = PW'(scale_re) * PW'(ei);
    assign ir = PW'(scale_im) * PW'(er);

    assign sum_re = SW'(rr) - SW'(ii) + HALF;
    assign sum_im = SW'(ri) + SW'(ir) + HALF;

    // arithmetic shift floors, so halves round up
    assign rnd_re = RW'(sum_re >>> csmc_pkg::SCALE_FRAC);
    assign rnd_im = RW'(sum_im >>> csmc_pkg::SCALE_FRAC);

    assign p_re = sat(rnd_re);
    assign p_im = sat(rnd_im);

endmodule

>>> rtl/complex_scaled_matrix_copy.sv
// ============================================================================
// complex_scaled_matrix_copy
// Streaming complex scaled matrix copy: B = alpha * op(A), one word a cycle unless m_ready stalls.
// ============================================================================
// Elements of A enter on the s_ channel in storage order (columns outer for
// column-major, rows outer for row-major). Each word is optionally conjugated,
// multiplied by the complex Q3.12 alpha, rounded half-up and saturated to
// Q0.15, and leaves on the m_ channel with its element index in B (straight
// or transposed per trans_mode) and a flag on the final element. Throughput
// is one word per cycle unless m_ready stalls it; two register stages: an
// input stage that captures the element and its loop position, and a result
// stage fed by the complex multiplier and the index multiplier. A result word
// passes the input stage, then the result stage, and stalls only on m_ready.
// Argument checks run on the live register values; on error each input word
// still yields one result word with write_ok low, the error code set, all
// other fields zero, and the loop position held. Configuration words are
// always accepted (cfg_ready is tied high) and must only be written while the
// pipeline is empty.
// ============================================================================
module complex_scaled_matrix_copy #(
    parameter int MAX_DIM    = 4096,
    parameter int DATA_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [csmc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csmc_pkg::CFG_DATA_W-1:0]      cfg_data,

    // element input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [DATA_WIDTH-1:0]         s_elem_re,
    input  logic signed [DATA_WIDTH-1:0]         s_elem_im,

    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [DATA_WIDTH-1:0]         m_out_re,
    output logic signed [DATA_WIDTH-1:0]         m_out_im,
    output logic [csmc_pkg::IDX_W-1:0]           m_dest_index,
    output logic                                 m_write_ok,
    output logic [2:0]                           m_error_code,
    output logic                                 m_last_elem
);

    localparam int POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MW    = 32;   // index product width before truncation

    csmc_pkg::cfg_t      cfg;
    csmc_pkg::err_code_t err;

    // handshake
    logic s_accept;
    logic out_free;      // result register can load this cycle
    logic s1_advance;    // input stage moves into result stage

    // loop position from the counters
    logic [POS_W-1:0] outer_cur, inner_cur;
    logic             last_cur;

    // input stage
    logic                         s1_valid_reg, s1_valid_next;
    logic signed [DATA_WIDTH-1:0] s1_re_reg, s1_im_reg;
    logic [POS_W-1:0]             s1_outer_reg, s1_inner_reg;
    logic                         s1_last_reg;
    csmc_pkg::err_code_t          s1_err_reg;

    // result-stage logic
    logic signed [DATA_WIDTH-1:0] p_re, p_im;
    logic [MW-1:0]                idx_full;
    logic                         s1_ok;

    // result stage
    logic                         m_valid_reg, m_valid_next;
    logic signed [DATA_WIDTH-1:0] m_re_reg, m_im_reg;
    logic [csmc_pkg::IDX_W-1:0]   m_idx_reg;
    logic                         m_ok_reg, m_last_reg;
    csmc_pkg::err_code_t          m_err_reg;

    csmc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .err       (err)
    );

    // result register loads when empty or being drained
    assign out_free   = !m_valid_reg || m_ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_ready    = !s1_valid_reg || out_free;
    assign s_accept   = s_valid && s_ready;

    // positions only move on words that pass the argument checks
    csmc_pos_ctr #(
        .MAX_DIM (MAX_DIM)
    ) u_pos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .advance   (s_accept && (err == csmc_pkg::ERR_NONE)),
        .outer_cur (outer_cur),
        .inner_cur (inner_cur),
        .last      (last_cur)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept)
            s1_valid_next = 1'b1;
        else if (s1_advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_re_reg    <= s_elem_re;
            s1_im_reg    <= s_elem_im;
            s1_outer_reg <= outer_cur;
            s1_inner_reg <= inner_cur;
            s1_last_reg  <= last_cur;
            s1_err_reg   <= err;
        end
    end

    csmc_cmul #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_cmul (
        .a_re     (s1_re_reg),
        .a_im     (s1_im_reg),
        .conj     (cfg.trans_mode[csmc_pkg::TM_CONJ_BIT]),
        .scale_re (cfg.scale_re),
        .scale_im (cfg.scale_im),
        .p_re     (p_re),
        .p_im     (p_im)
    );

    // B index: transposed modes swap which position is scaled by the stride
    always_comb begin
        if (cfg.trans_mode[csmc_pkg::TM_TRANS_BIT])
            idx_full = MW'(s1_inner_reg) * MW'(cfg.dst_stride) + MW'(s1_outer_reg);
        else
            idx_full = MW'(s1_outer_reg) * MW'(cfg.dst_stride) + MW'(s1_inner_reg);
    end

    assign s1_ok = (s1_err_reg == csmc_pkg::ERR_NONE);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_advance)
            m_valid_next = 1'b1;
        else if (m_ready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // error words carry zeros in every payload field but the code
    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            m_re_reg   <= s1_ok ? p_re : '0;
            m_im_reg   <= s1_ok ? p_im : '0;
            m_idx_reg  <= s1_ok ? idx_full[csmc_pkg::IDX_W-1:0] : '0;
            m_ok_reg   <= s1_ok;
            m_last_reg <= s1_ok && s1_last_reg;
            m_err_reg  <= s1_err_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_re     = m_re_reg;
    assign m_out_im     = m_im_reg;
    assign m_dest_index = m_idx_reg;
    assign m_write_ok   = m_ok_reg;
    assign m_error_code = m_err_reg;
    assign m_last_elem  = m_last_reg;

endmodule
